// ----- design/integer_key_sorter_core_assert.svh -----
// Assertion macros used by the integer key sorter top level.
// Needs no package; each macro takes its clock and active-low reset as arguments.
`ifndef INTEGER_KEY_SORTER_CORE_ASSERT_SVH
`define INTEGER_KEY_SORTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define IKS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define IKS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define IKS_ASSERT(lbl, clk, rst_n, prop, msg)
`define IKS_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- design/iks_pkg.sv -----
// Package for the integer key sorter: payload types, the cell link record,
// cell control and the state type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package iks_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [TAG_W-1:0]        tag_t;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic valid;
        logic greater;
        key_t key;
        tag_t tag;
    } link_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctrl_t;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } iks_state_t;

    // Left neighbor seen by the first cell: occupied and never larger.
    localparam link_t HEAD_LINK = '{valid: 1'b1, greater: 1'b0, key: '0, tag: '0};
    // Right neighbor seen by the last cell: empty.
    localparam link_t TAIL_LINK = '{valid: 1'b0, greater: 1'b0, key: '0, tag: '0};

endpackage

`default_nettype wire

// ----- design/iks_cell.sv -----
// One storage cell of the sorting chain: holds one entry and a valid bit.
// Depends on iks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iks_cell
    import iks_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire key_t       new_key,
    input  wire tag_t       new_tag,
    input  wire link_t      left,
    input  wire link_t      right,
    output link_t           self
);

    logic valid_reg, valid_next;
    key_t key_reg, key_next;
    tag_t tag_reg, tag_next;
    logic greater;

    // A stored key larger than the incoming one must move up a place.
    assign greater = valid_reg && (key_reg > new_key);

    assign self = '{valid: valid_reg, greater: greater, key: key_reg, tag: tag_reg};

    // Shift left while emitting; on insert, take the left neighbor if it moves
    // up, or the new item if this is its slot.
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        if (ctrl.shift_out)
        begin
            valid_next = right.valid;
            key_next   = right.key;
            tag_next   = right.tag;
        end
        else if (ctrl.insert && (greater || !valid_reg))
        begin
            if (left.greater)
            begin
                valid_next = 1'b1;
                key_next   = left.key;
                tag_next   = left.tag;
            end
            else if (left.valid)
            begin
                valid_next = 1'b1;
                key_next   = new_key;
                tag_next   = new_tag;
            end
        end
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

`default_nettype wire

// ----- design/iks_chain.sv -----
// Row of sorting cells, each linked to both neighbors.
// Depends on iks_pkg and iks_cell.
`timescale 1ns / 1ps
`default_nettype none

module iks_chain
    import iks_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire key_t       new_key,
    input  wire tag_t       new_tag,
    output key_t            head_key,
    output tag_t            head_tag
);

    link_t links [DEPTH];

    // Build the row; the ends see fixed neighbor records.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        link_t left_link;
        link_t right_link;

        if (i == 0)
        begin : g_first
            assign left_link = HEAD_LINK;
        end
        else
        begin : g_mid_left
            assign left_link = links[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_link = TAIL_LINK;
        end
        else
        begin : g_mid_right
            assign right_link = links[i+1];
        end

        iks_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .new_key (new_key),
            .new_tag (new_tag),
            .left    (left_link),
            .right   (right_link),
            .self    (links[i])
        );
    end

    // The smallest key always sits in the first cell.
    assign head_key = links[0].key;
    assign head_tag = links[0].tag;

endmodule

`default_nettype wire

// ----- design/integer_key_sorter_core.sv -----
// Top level of the integer key sorter: control, fill count and result registers.
// Depends on iks_pkg, iks_chain and integer_key_sorter_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "integer_key_sorter_core_assert.svh"

// Stable sorter of signed 32-bit keys with 16-bit tags, up to DEPTH entries.
// While loading, an item is taken every cycle that start is high and busy is
// low; each item is placed in sorted order by a row of DEPTH cells in the same
// cycle. An item with final_entry set (stored too, unless the row is full)
// starts the run: busy is high while the row shifts out all stored entries,
// one entry per cycle. Each result is loaded into the result registers on
// its emit step and shown one per cycle on result_valid,
// with run_end on the last; a new item can be taken in the cycle that shows
// the last result. Results cannot be held off, so the receiver must take each
// one in its cycle. Items arriving while the row is full are discarded and
// dropped is set on every result of that run.
module integer_key_sorter_core
    import iks_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire key_t sort_key,
    input  wire tag_t entry_tag,
    input  wire logic final_entry,
    output logic      result_valid,
    output key_t      sorted_key,
    output tag_t      sorted_tag,
    output logic      run_end,
    output logic      dropped
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    iks_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic overflow_reg, overflow_next;
    logic accept;
    logic full;
    logic last_out;
    cell_ctrl_t ctrl;
    key_t head_key;
    tag_t head_tag;

    logic valid_reg;
    key_t key_reg;
    tag_t tag_reg;
    logic end_reg;
    logic drop_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign last_out = (count_reg == CNT_W'(1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (start && final_entry)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (last_out)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State outputs: handshake and cell commands.
    always_comb
    begin
        busy           = 1'b0;
        ctrl.insert    = 1'b0;
        ctrl.shift_out = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                ctrl.insert = start && !full;
            end
            ST_EMIT:
            begin
                busy           = 1'b1;
                ctrl.shift_out = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign accept = start && !busy;

    // Fill count and overflow flag.
    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.shift_out)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (accept && full)
        begin
            overflow_next = 1'b1;
        end
        else if (ctrl.shift_out && last_out)
        begin
            overflow_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            valid_reg    <= ctrl.shift_out;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_out)
        begin
            key_reg  <= head_key;
            tag_reg  <= head_tag;
            end_reg  <= last_out;
            drop_reg <= overflow_reg;
        end
    end

    iks_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .new_key  (sort_key),
        .new_tag  (entry_tag),
        .head_key (head_key),
        .head_tag (head_tag)
    );

    assign result_valid = valid_reg;
    assign sorted_key   = key_reg;
    assign sorted_tag   = tag_reg;
    assign run_end      = end_reg;
    assign dropped      = drop_reg;

    // A result appears only in the cycle after an emit step.
    `IKS_ASSERT(a_result_after_emit, clk, rst_n, result_valid |-> $past(ctrl.shift_out), "result without emit step")
    // The row is never asked to shift out when it holds nothing.
    `IKS_NEVER(a_emit_empty, clk, rst_n, ctrl.shift_out && (count_reg == '0), "emit with empty row")
    // Inserting into a full row would lose the last entry.
    `IKS_NEVER(a_insert_full, clk, rst_n, ctrl.insert && full, "insert into full row")
    // The last emit step leaves the row empty and ready for a new set.
    `IKS_ASSERT(a_emit_clears, clk, rst_n, (ctrl.shift_out && last_out) |=> (count_reg == '0) && !overflow_reg && !busy, "run end did not clear state")

endmodule

`default_nettype wire
